### rtl/core/hsv2rgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter - shared types and constants
// Item format passed from the front end to the back end, sector codes and
// fixed-point constants for the hue and unit scaling.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Hue in 1/16 degree: one turn and one 60-degree sector
  localparam logic [12:0] HUE_TURN   = 13'd5760;
  localparam logic [12:0] HUE_SECTOR = 13'd960;

  // 1.0 in unsigned Q0.16
  localparam logic [16:0] UNIT_Q16 = 17'h10000;

  typedef logic [2:0] sector_t;

  // Sectors named by the hue span they cover; odd codes run hue downward
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  // Classified item: sector, weight of X in 1/960 steps, S and V in Q0.16
  typedef struct packed {
    sector_t     sector;
    logic [9:0]  k;
    logic [16:0] sat;
    logic [16:0] val;
  } item_t;

endpackage
`default_nettype wire

### rtl/core/hsv2rgb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter - front end
// Takes transactions, wraps hue into one turn, finds the sector and the
// position inside it, and turns saturation and value into Q0.16 units.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  hue,
  input  logic signed [15:0]  saturation,
  input  logic signed [15:0]  brightness,
  input  logic                q_full,
  output logic                push,
  output hsv2rgb_pkg::item_t  item
);
  import hsv2rgb_pkg::*;

  localparam logic [17:0] HUE_BIAS  = 18'd34560;   // six turns, keeps hue positive
  localparam logic [17:0] HUE_RECIP = 18'd186414;  // ceil(2^30 / 5760)
  localparam logic [15:0] PCT_RECIP = 16'd41944;   // ceil(2^20 / 25)

  // floor(r * 64 / 25) for a remainder r below 25
  localparam logic [5:0] PCT_FRAC [32] = '{
    6'd0,  6'd2,  6'd5,  6'd7,  6'd10, 6'd12, 6'd15, 6'd17,
    6'd20, 6'd23, 6'd25, 6'd28, 6'd30, 6'd33, 6'd35, 6'd38,
    6'd40, 6'd43, 6'd46, 6'd48, 6'd51, 6'd53, 6'd56, 6'd58,
    6'd61, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

  localparam logic [12:0] BASE1 = 13'(1 * HUE_SECTOR);
  localparam logic [12:0] BASE2 = 13'(2 * HUE_SECTOR);
  localparam logic [12:0] BASE3 = 13'(3 * HUE_SECTOR);
  localparam logic [12:0] BASE4 = 13'(4 * HUE_SECTOR);
  localparam logic [12:0] BASE5 = 13'(5 * HUE_SECTOR);

  // Q8.8 raw to Q0.16; above 1.0 the raw value is a percentage (raw*256/100)
  function automatic logic [16:0] unit_q16(input logic [15:0] raw, input logic [10:0] qr);
    logic [15:0] rem;
    logic [16:0] q;
    rem = raw - 16'(qr) * 16'd25;
    q   = {qr, 6'b0} + 17'(PCT_FRAC[rem[4:0]]);
    if (raw[15] || raw == 16'd0) begin
      unit_q16 = '0;
    end else if (raw <= 16'd256) begin
      unit_q16 = {raw[8:0], 8'b0};
    end else if (q > UNIT_Q16) begin
      unit_q16 = UNIT_Q16;
    end else begin
      unit_q16 = q;
    end
  endfunction

  logic        adv;
  logic        a_valid, b_valid, c_valid;

  logic [16:0] a_u;
  logic [3:0]  a_hq;
  logic [15:0] a_sraw, a_vraw;
  logic [10:0] a_sqr, a_vqr;

  logic [12:0] b_hu;
  logic [16:0] b_sat, b_val;

  logic [17:0] hue_biased;
  logic [34:0] hue_prod;
  logic [30:0] sat_prod, val_prod;
  logic [16:0] hu_full;
  sector_t     sec;
  logic [12:0] base;
  logic [12:0] f_full;
  logic [9:0]  f;

  assign busy = c_valid && q_full;
  assign adv  = !busy;
  assign push = c_valid && !q_full;

  assign hue_biased = {{2{hue[15]}}, hue} + HUE_BIAS;
  assign hue_prod   = 35'(hue_biased[16:0]) * 35'(HUE_RECIP);
  assign sat_prod   = 31'(saturation[14:0]) * 31'(PCT_RECIP);
  assign val_prod   = 31'(brightness[14:0]) * 31'(PCT_RECIP);

  assign hu_full = a_u - 17'(a_hq) * 17'(HUE_TURN);

  always_comb begin
    if (b_hu < BASE1) begin
      sec  = SEC_RED_YEL;
      base = '0;
    end else if (b_hu < BASE2) begin
      sec  = SEC_YEL_GRN;
      base = BASE1;
    end else if (b_hu < BASE3) begin
      sec  = SEC_GRN_CYN;
      base = BASE2;
    end else if (b_hu < BASE4) begin
      sec  = SEC_CYN_BLU;
      base = BASE3;
    end else if (b_hu < BASE5) begin
      sec  = SEC_BLU_MAG;
      base = BASE4;
    end else begin
      sec  = SEC_MAG_RED;
      base = BASE5;
    end
    f_full = b_hu - base;
    f      = f_full[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= start;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_u         <= hue_biased[16:0];
      a_hq        <= hue_prod[33:30];
      a_sraw      <= saturation;
      a_vraw      <= brightness;
      a_sqr       <= sat_prod[30:20];
      a_vqr       <= val_prod[30:20];
      b_hu        <= hu_full[12:0];
      b_sat       <= unit_q16(a_sraw, a_sqr);
      b_val       <= unit_q16(a_vraw, a_vqr);
      item.sector <= sec;
      // odd sectors weight X by the distance to the sector's end
      item.k      <= sec[0] ? 10'(HUE_SECTOR - 13'(f)) : f;
      item.sat    <= b_sat;
      item.val    <= b_val;
    end
  end

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> b_hu < HUE_TURN)
    else $error("wrapped hue out of range");

endmodule
`default_nettype wire

### rtl/core/hsv2rgb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter - item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module hsv2rgb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsv2rgb_pkg::item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output hsv2rgb_pkg::item_t rd_item
);
  import hsv2rgb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full    = count == CW'(DEPTH);
  assign valid   = count != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH) && !(push && full))
    else $error("queue overflow");

endmodule
`default_nettype wire

### rtl/core/hsv2rgb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter - back end
// Pipelined arithmetic: chroma, offset, intermediate component X = C*k/960,
// sector placement and scaling of each channel to 0..255.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hsv2rgb_pkg::item_t in_item,
  output logic               pop,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);
  import hsv2rgb_pkg::*;

  localparam logic [20:0] QA_RECIP = 21'd1118482;   // ceil(2^24 / 15)
  localparam logic [26:0] QT_RECIP = 27'd71582789;  // ceil(2^30 / 15)

  // floor(sum * 255 / 2^32); sum never exceeds 2^32 so the result fits a byte
  function automatic logic [7:0] to_byte(input logic [32:0] sum);
    logic [40:0] scaled;
    scaled  = {sum, 8'b0} - 41'(sum);
    to_byte = scaled[39:32];
  endfunction

  logic [5:0]  vld;

  logic [32:0] s1_c;
  logic [25:0] s1_p;
  logic [16:0] s1_s, s1_v;
  sector_t     s1_sec;

  logic [41:0] s2_n;
  logic [32:0] s2_c, s2_m;
  sector_t     s2_sec;

  logic [15:0] s3_a;
  logic [12:0] s3_qa;
  logic [19:0] s3_b;
  logic [32:0] s3_c, s3_m;
  sector_t     s3_sec;

  logic [23:0] s4_t;
  logic [12:0] s4_qa;
  logic [32:0] s4_c, s4_m;
  sector_t     s4_sec;

  logic [32:0] s5_x, s5_c, s5_m;
  sector_t     s5_sec;

  logic [32:0] s6_r, s6_g, s6_b;

  logic [33:0] cv_prod;
  logic [26:0] vk_prod;
  logic [42:0] n_prod;
  logic [36:0] qa_prod;
  logic [15:0] ra_full;
  logic [50:0] qt_prod;
  logic [32:0] r_comp, g_comp, b_comp;

  assign pop = in_valid;

  assign cv_prod = 34'(in_item.sat) * 34'(in_item.val);
  assign vk_prod = 27'(in_item.val) * 27'(in_item.k);
  assign n_prod  = 43'(s1_s) * 43'(s1_p);
  // N / 960 = (N >> 6) / 15, split into a high and a low part
  assign qa_prod = 37'(s2_n[41:26]) * 37'(QA_RECIP);
  assign ra_full = s3_a - 16'(s3_qa) * 16'd15;
  assign qt_prod = 51'(s4_t) * 51'(QT_RECIP);

  always_comb begin
    r_comp = '0;
    g_comp = '0;
    b_comp = '0;
    case (s5_sec)
      SEC_RED_YEL: begin
        r_comp = s5_c;
        g_comp = s5_x;
      end
      SEC_YEL_GRN: begin
        r_comp = s5_x;
        g_comp = s5_c;
      end
      SEC_GRN_CYN: begin
        g_comp = s5_c;
        b_comp = s5_x;
      end
      SEC_CYN_BLU: begin
        g_comp = s5_x;
        b_comp = s5_c;
      end
      SEC_BLU_MAG: begin
        r_comp = s5_x;
        b_comp = s5_c;
      end
      default: begin
        r_comp = s5_c;
        b_comp = s5_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:0], pop};
      done <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    s1_c   <= cv_prod[32:0];
    s1_p   <= vk_prod[25:0];
    s1_s   <= in_item.sat;
    s1_v   <= in_item.val;
    s1_sec <= in_item.sector;

    s2_n   <= n_prod[41:0];
    s2_m   <= (33'(s1_v) << 16) - s1_c;
    s2_c   <= s1_c;
    s2_sec <= s1_sec;

    s3_a   <= s2_n[41:26];
    s3_qa  <= qa_prod[36:24];
    s3_b   <= s2_n[25:6];
    s3_c   <= s2_c;
    s3_m   <= s2_m;
    s3_sec <= s2_sec;

    // remainder of the high part rejoins the low bits
    s4_t   <= {ra_full[3:0], s3_b};
    s4_qa  <= s3_qa;
    s4_c   <= s3_c;
    s4_m   <= s3_m;
    s4_sec <= s3_sec;

    s5_x   <= {s4_qa, 20'b0} + 33'(qt_prod[49:30]);
    s5_c   <= s4_c;
    s5_m   <= s4_m;
    s5_sec <= s4_sec;

    s6_r   <= r_comp + s5_m;
    s6_g   <= g_comp + s5_m;
    s6_b   <= b_comp + s5_m;

    red    <= to_byte(s6_r);
    green  <= to_byte(s6_g);
    blue   <= to_byte(s6_b);
  end

  a_x_below_chroma: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> s5_x <= s5_c)
    else $error("intermediate component exceeds chroma");

endmodule
`default_nettype wire

### rtl/core/hsv_to_rgb_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter - top level
// Front end classifies each transaction, a short queue decouples it from the
// pipelined arithmetic back end that produces the RGB bytes.
// ----------------------------------------------------------------------------
// A result passes through the front end stages, the queue and the back end stages.
// Throughput: one transaction per clock; the back end pipeline never stalls,
// so with QUEUE_DEPTH above one busy stays low; the queue holds at most one item.
// Reset: synchronous; clears all valid flags and the queue, drops items in
// flight. The receiver cannot stall: each result is shown for one cycle.
module hsv_to_rgb_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] hue,
  input  logic signed [15:0] saturation,
  input  logic signed [15:0] brightness,
  output logic               done,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);
  import hsv2rgb_pkg::*;

  localparam int LATENCY = 11;

  logic  q_full, q_push, q_valid, q_pop;
  item_t front_item, head_item;

  hsv2rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .q_full     (q_full),
    .push       (q_push),
    .item       (front_item)
  );

  hsv2rgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (front_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (head_item)
  );

  hsv2rgb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (head_item),
    .pop      (q_pop),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("front end stalled");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result strobe missing after accepted transaction");

endmodule
`default_nettype wire
